FILE: rtl/core/mes_pkg.sv
`default_nettype none

package mes_pkg;

  // Action codes reported with each result.
  localparam logic [2:0] ACT_LEFT    = 3'd0;
  localparam logic [2:0] ACT_FORWARD = 3'd1;
  localparam logic [2:0] ACT_RIGHT   = 3'd2;
  localparam logic [2:0] ACT_TURN    = 3'd3;
  localparam logic [2:0] ACT_NONE    = 3'd4;

  // Headings. North is row + 1, east is column + 1.
  localparam logic [1:0] HEAD_N = 2'd0;
  localparam logic [1:0] HEAD_E = 2'd1;
  localparam logic [1:0] HEAD_S = 2'd2;
  localparam logic [1:0] HEAD_W = 2'd3;

  // Configuration register indexes.
  localparam logic REG_GOAL_X = 1'b0;
  localparam logic REG_GOAL_Y = 1'b1;

  localparam logic [3:0] GOAL_RESET = 4'd8;

  typedef struct packed {
    logic wall_left;
    logic wall_front;
    logic wall_right;
  } step_req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] new_heading;
    logic [3:0] new_col;
    logic [3:0] new_row;
    logic       revisited;
    logic       at_goal;
  } step_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/mes_visit_map.sv
`default_nettype none

module mes_visit_map import mes_pkg::*; #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16,
  localparam int COL_W = $clog2(GRID_WIDTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   rd_en,
  input  wire logic [COL_W-1:0]       rd_addr_w,
  input  wire logic [COL_W-1:0]       rd_addr_c,
  input  wire logic [COL_W-1:0]       rd_addr_e,
  output      logic [GRID_HEIGHT-1:0] rd_word_w,
  output      logic [GRID_HEIGHT-1:0] rd_word_c,
  output      logic [GRID_HEIGHT-1:0] rd_word_e,
  input  wire logic                   wr_en,
  input  wire logic [COL_W-1:0]       wr_addr,
  input  wire logic [GRID_HEIGHT-1:0] wr_word
);

  // Two copies of the column-organized map: one serves the west and east
  // neighbour columns, the other the current column. Both take every write.
  logic [GRID_HEIGHT-1:0] side_mem [GRID_WIDTH];
  logic [GRID_HEIGHT-1:0] ctr_mem  [GRID_WIDTH];
  logic [GRID_WIDTH-1:0]  col_valid;

  logic [GRID_HEIGHT-1:0] word_w_q, word_c_q, word_e_q;
  logic                   ok_w, ok_c, ok_e;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      side_mem[wr_addr] <= wr_word;
      ctr_mem[wr_addr]  <= wr_word;
    end
    if (rd_en) begin
      word_w_q <= side_mem[rd_addr_w];
      word_e_q <= side_mem[rd_addr_e];
      word_c_q <= ctr_mem[rd_addr_c];
    end
  end

  // A column never written reads as all cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= '0;
      ok_w      <= 1'b0;
      ok_c      <= 1'b0;
      ok_e      <= 1'b0;
    end else begin
      if (wr_en) begin
        col_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        ok_w <= col_valid[rd_addr_w];
        ok_c <= col_valid[rd_addr_c];
        ok_e <= col_valid[rd_addr_e];
      end
    end
  end

  assign rd_word_w = ok_w ? word_w_q : '0;
  assign rd_word_c = ok_c ? word_c_q : '0;
  assign rd_word_e = ok_e ? word_e_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/mes_step_logic.sv
`default_nettype none

module mes_step_logic import mes_pkg::*; #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16,
  localparam int COL_W = $clog2(GRID_WIDTH),
  localparam int ROW_W = $clog2(GRID_HEIGHT)
) (
  input  wire step_req_t              req,
  input  wire logic [COL_W-1:0]       col,
  input  wire logic [ROW_W-1:0]       row,
  input  wire logic [1:0]             heading,
  input  wire logic [3:0]             goal_x,
  input  wire logic [3:0]             goal_y,
  input  wire logic [GRID_HEIGHT-1:0] word_w,
  input  wire logic [GRID_HEIGHT-1:0] word_c,
  input  wire logic [GRID_HEIGHT-1:0] word_e,
  output      logic [COL_W-1:0]       col_next,
  output      logic [ROW_W-1:0]       row_next,
  output      logic [1:0]             heading_next,
  output      logic                   map_wr,
  output      logic [GRID_HEIGHT-1:0] map_word,
  output      step_rsp_t              rsp
);

  logic [3:0]       on_dir;
  logic [3:0]       vis_dir;
  logic [ROW_W-1:0] row_up, row_dn;
  logic [COL_W-1:0] col_e, col_w;
  logic [1:0]       side_dir [3];
  logic [2:0]       wall, open, seen;
  logic [2:0]       action;
  logic [1:0]       move_dir;
  logic             at_goal_now;
  logic [COL_W+3:0] col_ext, col_next_ext, goal_col_ext;
  logic [ROW_W+3:0] row_ext, row_next_ext, goal_row_ext;

  always_comb begin
    on_dir[HEAD_N] = (row != ROW_W'(GRID_HEIGHT - 1));
    on_dir[HEAD_E] = (col != COL_W'(GRID_WIDTH - 1));
    on_dir[HEAD_S] = (row != '0);
    on_dir[HEAD_W] = (col != '0);

    row_up = on_dir[HEAD_N] ? ROW_W'(row + 1'b1) : row;
    row_dn = on_dir[HEAD_S] ? ROW_W'(row - 1'b1) : row;
    col_e  = on_dir[HEAD_E] ? COL_W'(col + 1'b1) : col;
    col_w  = on_dir[HEAD_W] ? COL_W'(col - 1'b1) : col;

    vis_dir[HEAD_N] = word_c[row_up];
    vis_dir[HEAD_S] = word_c[row_dn];
    vis_dir[HEAD_E] = word_e[row];
    vis_dir[HEAD_W] = word_w[row];

    side_dir[0] = heading + 2'd3;
    side_dir[1] = heading;
    side_dir[2] = heading + 2'd1;

    wall = {req.wall_right, req.wall_front, req.wall_left};
    for (int i = 0; i < 3; i++) begin
      open[i] = on_dir[side_dir[i]] & ~wall[i];
      seen[i] = on_dir[side_dir[i]] & vis_dir[side_dir[i]];
    end
  end

  // Unvisited sides first (left, front, right), then any open side
  // (right, front, left), else turn around.
  always_comb begin
    priority if (open[0] && !seen[0]) begin
      action = ACT_LEFT;
    end else if (open[1] && !seen[1]) begin
      action = ACT_FORWARD;
    end else if (open[2] && !seen[2]) begin
      action = ACT_RIGHT;
    end else if (open[2]) begin
      action = ACT_RIGHT;
    end else if (open[1]) begin
      action = ACT_FORWARD;
    end else if (open[0]) begin
      action = ACT_LEFT;
    end else begin
      action = ACT_TURN;
    end
  end

  always_comb begin
    col_ext      = {4'b0, col};
    row_ext      = {4'b0, row};
    goal_col_ext = {{COL_W{1'b0}}, goal_x};
    goal_row_ext = {{ROW_W{1'b0}}, goal_y};
    at_goal_now  = (col_ext == goal_col_ext) && (row_ext == goal_row_ext);

    move_dir = side_dir[0];
    unique case (action)
      ACT_LEFT:    move_dir = side_dir[0];
      ACT_FORWARD: move_dir = side_dir[1];
      ACT_RIGHT:   move_dir = side_dir[2];
      default:     move_dir = side_dir[0];
    endcase

    col_next     = col;
    row_next     = row;
    heading_next = heading;
    if (at_goal_now) begin
      heading_next = heading;
    end else if (action == ACT_TURN) begin
      heading_next = heading + 2'd2;
    end else begin
      heading_next = move_dir;
      unique case (move_dir)
        HEAD_N:  row_next = row_up;
        HEAD_E:  col_next = col_e;
        HEAD_S:  row_next = row_dn;
        HEAD_W:  col_next = col_w;
        default: row_next = row;
      endcase
    end

    map_wr   = !at_goal_now;
    map_word = word_c | (GRID_HEIGHT'(1) << row);

    col_next_ext = {4'b0, col_next};
    row_next_ext = {4'b0, row_next};

    rsp.action      = at_goal_now ? ACT_NONE : action;
    rsp.new_heading = heading_next;
    rsp.new_col     = col_next_ext[3:0];
    rsp.new_row     = row_next_ext[3:0];
    rsp.revisited   = word_c[row];
    rsp.at_goal     = (col_next_ext == goal_col_ext) && (row_next_ext == goal_row_ext);
  end

endmodule

`default_nettype wire

FILE: rtl/core/maze_explore_step_unit.sv
// A request reads the map and sets busy when it is accepted; its result is then
//   registered into the output register, or into the skid entry if that is held.
// A new request is not taken while one is being resolved; the pose loop (map
//   read, decision, pose update) through the registered map read sets this limit.
// Reset: pose to column 0, row 0, heading north; goal to (8, 8); the visited
//   map is cleared in the same cycle through per-column valid bits.
`default_nettype none

module maze_explore_step_unit import mes_pkg::*; #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire step_req_t in_req,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      step_rsp_t out_rsp,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_index,
  input  wire logic [3:0] cfg_wr_data
);

  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT);

  // Pose and goal registers.
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [1:0]       heading;
  logic [3:0]       goal_x, goal_y;

  // The request in flight: busy is high in the cycle after acceptance,
  // when the map words have arrived and the step is resolved.
  logic      busy;
  step_req_t req_q;

  logic accept, pop;

  // Output register plus one skid entry, so a new request can be taken
  // while a finished result still waits at the output.
  step_rsp_t skid_rsp;
  logic      skid_valid;

  logic [COL_W-1:0]       rd_addr_w, rd_addr_e;
  logic [GRID_HEIGHT-1:0] word_w, word_c, word_e;

  logic [COL_W-1:0]       col_next;
  logic [ROW_W-1:0]       row_next;
  logic [1:0]             heading_next;
  logic                   map_wr;
  logic [GRID_HEIGHT-1:0] map_word;
  step_rsp_t              step_rsp;

  // The next request must see the pose left by the one in flight, so the
  // input side waits out the resolve cycle. The skid entry must be free.
  assign in_ready = !busy && !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  // Neighbour column addresses fall back to the current column at the grid
  // edge; those reads are masked out by the bounds checks anyway.
  assign rd_addr_w = (col != '0) ? COL_W'(col - 1'b1) : col;
  assign rd_addr_e = (col != COL_W'(GRID_WIDTH - 1)) ? COL_W'(col + 1'b1) : col;

  mes_visit_map #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr_w(rd_addr_w),
    .rd_addr_c(col),
    .rd_addr_e(rd_addr_e),
    .rd_word_w(word_w),
    .rd_word_c(word_c),
    .rd_word_e(word_e),
    .wr_en    (busy && map_wr),
    .wr_addr  (col),
    .wr_word  (map_word)
  );

  mes_step_logic #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_step (
    .req         (req_q),
    .col         (col),
    .row         (row),
    .heading     (heading),
    .goal_x      (goal_x),
    .goal_y      (goal_y),
    .word_w      (word_w),
    .word_c      (word_c),
    .word_e      (word_e),
    .col_next    (col_next),
    .row_next    (row_next),
    .heading_next(heading_next),
    .map_wr      (map_wr),
    .map_word    (map_word),
    .rsp         (step_rsp)
  );

  // Wall bits are held for the resolve cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= in_req;
    end
  end

  // Control, pose and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      col     <= '0;
      row     <= '0;
      heading <= HEAD_N;
      goal_x  <= GOAL_RESET;
      goal_y  <= GOAL_RESET;
    end else begin
      busy <= accept;
      if (busy) begin
        col     <= col_next;
        row     <= row_next;
        heading <= heading_next;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_GOAL_X: goal_x <= cfg_wr_data;
          REG_GOAL_Y: goal_y <= cfg_wr_data;
          default:    goal_x <= goal_x;
        endcase
      end
    end
  end

  // Output queue. A new result goes to the output register when it is empty
  // or being taken, otherwise into the skid entry. The skid entry is always
  // empty when a result is produced, since no request is accepted while it
  // is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (busy) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (!out_valid || pop) begin
        out_rsp <= step_rsp;
      end else begin
        skid_rsp <= step_rsp;
      end
    end else if (pop && skid_valid) begin
      out_rsp <= skid_rsp;
    end
  end

  // Two requests are never accepted on back-to-back edges: the second must
  // read the map with the pose the first one leaves.
  a_no_back_to_back_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !accept)
    else $error("request accepted while the previous step was unresolved");

  // Every accepted request has a result waiting at the output once its resolve
  // cycle is over.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 out_valid)
    else $error("no result after an accepted request");

  // The map is written only while resolving a request.
  a_map_write_timing: assert property (@(posedge clk) disable iff (rst)
    (busy && map_wr) |-> $past(accept))
    else $error("map write outside the resolve cycle");

  // The skid entry only ever holds a result behind a waiting one.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while the output register is empty");

endmodule

`default_nettype wire

FILE: dv/tb_maze_explore_step_unit.sv
`timescale 1ns / 1ps

module tb_maze_explore_step_unit;
  import mes_pkg::*;

  localparam int IDLE_PCT       = 11;
  localparam int TOTAL_STEPS    = 1650;
  localparam int STALL_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 5000;
  // Requests and results in this window are sent and taken without random idle gaps.
  localparam int QUIET_FROM     = 700;
  localparam int QUIET_TO       = 1000;
  // The long receiver hold-off starts once this many results have come back.
  localparam int STALL_AT       = 400;
  localparam logic [3:0] LAST_CELL = 4'd15;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  step_req_t in_req = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  step_rsp_t out_rsp;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_index = REG_GOAL_X;
  logic [3:0] cfg_wr_data = '0;

  maze_explore_step_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Wall readings waiting to be sent, and the moves the mouse is expected to
  // report for requests that have already been accepted.
  step_req_t wall_readings[$];
  step_rsp_t pending_moves[$];

  int mismatches = 0;
  int req_count  = 0;
  int rsp_count  = 0;
  int quiet_cycles = 0;

  // Our own copy of the mouse: goal registers, pose and the visited map.
  // The map is indexed by {column, row}, which matches column * 16 + row.
  logic [3:0]   goal_col = GOAL_RESET;
  logic [3:0]   goal_row = GOAL_RESET;
  logic [3:0]   pose_col = '0;
  logic [3:0]   pose_row = '0;
  logic [1:0]   pose_head = HEAD_N;
  logic [255:0] visited = '0;

  // Works out one exploration step and advances the model pose. Side 0 is
  // left, side 1 is front and side 2 is right of the current heading.
  function automatic step_rsp_t next_pose(step_req_t walls);
    logic [2:0]      blocked;
    logic [2:0]      open_side;
    logic [2:0]      fresh_side;
    logic [2:0][1:0] nb_dir;
    logic [2:0][3:0] nb_col;
    logic [2:0][3:0] nb_row;
    logic            on_grid;
    logic            was_seen;
    int              pick;
    step_rsp_t       rsp;
    blocked  = {walls.wall_right, walls.wall_front, walls.wall_left};
    was_seen = visited[{pose_col, pose_row}];
    pick     = -1;
    if (pose_col == goal_col && pose_row == goal_row) begin
      // Already parked on the goal: no move, no turn, no map write.
      rsp.action = ACT_NONE;
    end else begin
      for (int s = 0; s < 3; s++) begin
        nb_dir[s] = pose_head - 2'd1 + 2'(s);
        nb_col[s] = pose_col;
        nb_row[s] = pose_row;
        // A neighbour that falls off the grid is treated as a wall.
        case (nb_dir[s])
          HEAD_N: begin
            on_grid   = pose_row != LAST_CELL;
            nb_row[s] = pose_row + 4'd1;
          end
          HEAD_E: begin
            on_grid   = pose_col != LAST_CELL;
            nb_col[s] = pose_col + 4'd1;
          end
          HEAD_S: begin
            on_grid   = pose_row != 4'd0;
            nb_row[s] = pose_row - 4'd1;
          end
          default: begin
            on_grid   = pose_col != 4'd0;
            nb_col[s] = pose_col - 4'd1;
          end
        endcase
        open_side[s]  = on_grid && !blocked[s];
        fresh_side[s] = open_side[s] && !visited[{nb_col[s], nb_row[s]}];
      end
      // Unvisited cells win in the order left, front, right; otherwise any
      // open side in the order right, front, left.
      for (int s = 0; s < 3; s++)
        if (pick < 0 && fresh_side[s]) pick = s;
      for (int s = 2; s >= 0; s--)
        if (pick < 0 && open_side[s]) pick = s;
      visited[{pose_col, pose_row}] = 1'b1;
      if (pick >= 0) begin
        case (pick)
          0:       rsp.action = ACT_LEFT;
          1:       rsp.action = ACT_FORWARD;
          default: rsp.action = ACT_RIGHT;
        endcase
        pose_head = nb_dir[pick];
        pose_col  = nb_col[pick];
        pose_row  = nb_row[pick];
      end else begin
        // Boxed in: spin around on the spot.
        rsp.action = ACT_TURN;
        pose_head  = pose_head + 2'd2;
      end
    end
    rsp.new_heading = pose_head;
    rsp.new_col     = pose_col;
    rsp.new_row     = pose_row;
    rsp.revisited   = was_seen;
    rsp.at_goal     = pose_col == goal_col && pose_row == goal_row;
    return rsp;
  endfunction

  task automatic report_field(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Request driver. A new request is only put up once the previous one has
  // been taken, and valid is held with a stable payload until then.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (wall_readings.size() != 0 &&
          ((req_count >= QUIET_FROM && req_count < QUIET_TO) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        in_req   <= wall_readings.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. Besides the random stalls it holds off once for a long
  // stretch so that the block backs up and has to refuse requests.
  int   stall_left = 0;
  logic stall_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!stall_done && rsp_count >= STALL_AT) begin
      stall_done <= 1'b1;
      stall_left <= STALL_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= (rsp_count >= QUIET_FROM && rsp_count < QUIET_TO) ||
                   $urandom_range(99) >= IDLE_PCT;
    end
  end

  // Monitor: predicts each accepted request, checks each accepted result
  // against the oldest prediction, and watches for a hung handshake.
  always @(posedge clk) begin : monitor
    step_rsp_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_moves.size() == 0) begin
          $display("%0t: result with no request outstanding, actual %p", $time, out_rsp);
          mismatches++;
        end else begin
          want = pending_moves.pop_front();
          if (out_rsp.action !== want.action)
            report_field("action", want.action, out_rsp.action);
          if (out_rsp.new_heading !== want.new_heading)
            report_field("new_heading", want.new_heading, out_rsp.new_heading);
          if (out_rsp.new_col !== want.new_col)
            report_field("new_col", want.new_col, out_rsp.new_col);
          if (out_rsp.new_row !== want.new_row)
            report_field("new_row", want.new_row, out_rsp.new_row);
          if (out_rsp.revisited !== want.revisited)
            report_field("revisited", want.revisited, out_rsp.revisited);
          if (out_rsp.at_goal !== want.at_goal)
            report_field("at_goal", want.at_goal, out_rsp.at_goal);
        end
        rsp_count++;
      end
      if (in_valid && in_ready) begin
        pending_moves.push_back(next_pose(in_req));
        req_count++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Blocks until every queued request has been sent and every result is in,
  // then lets the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (wall_readings.size() != 0 || in_valid || pending_moves.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Goal registers are only written while the block is idle, so the model
  // copy can be updated on the spot.
  task automatic write_goal(logic [3:0] col, logic [3:0] row);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_GOAL_X;
    cfg_wr_data <= col;
    @(posedge clk);
    cfg_index   <= REG_GOAL_Y;
    cfg_wr_data <= row;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    goal_col = col;
    goal_row = row;
  endtask

  initial begin : stimulus
    logic [3:0] gx;
    logic [3:0] gy;
    int         density;
    int         phase_len;
    int         sent;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with the reset goal: a forward step from the corner
    // with the west side off the grid, then right and left moves, two turn
    // arounds in a dead end, and every combination of the three wall bits.
    @(negedge clk);
    wall_readings.push_back(step_req_t'(3'b000));
    wall_readings.push_back(step_req_t'(3'b110));
    wall_readings.push_back(step_req_t'(3'b011));
    wall_readings.push_back(step_req_t'(3'b111));
    wall_readings.push_back(step_req_t'(3'b111));
    for (int w = 0; w < 8; w++)
      wall_readings.push_back(step_req_t'(3'(w)));
    wait_drained();

    // Park the goal on the mouse: it should stay put and report the goal.
    write_goal(pose_col, pose_row);
    @(negedge clk);
    wall_readings.push_back(step_req_t'(3'b000));
    wall_readings.push_back(step_req_t'(3'b101));
    wait_drained();
    sent = 15;

    // Random phases. Each one moves the goal and then sends a batch of wall
    // readings with its own wall density, from open floor to nearly boxed in.
    while (sent < TOTAL_STEPS) begin
      case ($urandom_range(4))
        0: begin
          gx = pose_col;
          gy = pose_row;
        end
        1: begin
          gx = $urandom_range(1) ? LAST_CELL : 4'd0;
          gy = $urandom_range(1) ? LAST_CELL : 4'd0;
        end
        2: begin
          gx = pose_col + 4'($urandom_range(2)) - 4'd1;
          gy = pose_row + 4'($urandom_range(2)) - 4'd1;
        end
        default: begin
          gx = 4'($urandom_range(15));
          gy = 4'($urandom_range(15));
        end
      endcase
      write_goal(gx, gy);
      density   = 20 * $urandom_range(4);
      phase_len = $urandom_range(20, 60);
      @(negedge clk);
      for (int i = 0; i < phase_len; i++) begin
        wall_readings.push_back('{wall_left:  $urandom_range(99) < density,
                                  wall_front: $urandom_range(99) < density,
                                  wall_right: $urandom_range(99) < density});
      end
      sent += phase_len;
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
